// ===== src/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

    // Default sizing of the pool and its block table.
    localparam int POOL_BYTES_DEF   = 2048;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int MAX_BLOCKS_DEF   = 128;

    // Fixed widths of the request and result fields.
    localparam int REQ_W   = 12;
    localparam int FADDR_W = 11;
    localparam int PADDR_W = 11;
    localparam int ST_W    = 2;

    // Request opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [ST_W-1:0] ST_NULL  = 2'd2;

    // Operation that the cell row performs in the current cycle.
    typedef logic [2:0] ffba_mode_t;
    localparam ffba_mode_t MODE_IDLE      = 3'd0;
    localparam ffba_mode_t MODE_HIT_ALLOC = 3'd1;
    localparam ffba_mode_t MODE_HIT_FREE  = 3'd2;
    localparam ffba_mode_t MODE_ALLOC     = 3'd3;
    localparam ffba_mode_t MODE_MARK      = 3'd4;
    localparam ffba_mode_t MODE_MERGE     = 3'd5;

    // One request beat.
    typedef struct packed {
        logic               op;
        logic [REQ_W-1:0]   req_size;
        logic [FADDR_W-1:0] free_addr;
        logic               null_pointer;
    } ffba_req_t;

    // One result beat.
    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [PADDR_W-1:0] payload_addr;
    } ffba_rsp_t;

    // Command broadcast to every cell.
    typedef struct packed {
        ffba_mode_t         mode;
        logic [REQ_W-1:0]   req_size;
        logic [FADDR_W-1:0] free_addr;
        logic               do_split;
    } ffba_ctrl_t;

    // Status that a cell shows to its neighbors and to the controller.
    typedef struct packed {
        logic valid;
        logic free;
        logic flag;
        logic first;
        logic split_ok;
    } ffba_stat_t;

endpackage

`default_nettype wire

// ===== src/first_fit_block_allocator_unit.sv =====
`default_nettype none

// First-fit block allocator with coalescing. The pool is kept as an
// address-ordered row of MAX_BLOCKS table cells, one block per cell. A
// request beat is taken when start is high and busy is low. An allocate
// keeps busy high through S_HIT, in which every cell compares its block
// against the request, and S_ALLOC, in which the first fitting cell is
// picked and the cells behind it shift up to make room for the split. A
// release keeps busy high through S_HIT for the address compare, S_MARK
// for the free mark, and S_MERGE, which merges neighboring free blocks
// until it finds nothing left to merge. A release with null_pointer set
// ends after S_HIT. The result beat is shown on result for exactly one
// cycle with done high, in the cycle in which busy falls; there is no way
// to hold it off, so the receiver must take it then. A new request may be
// started in that same cycle. Ungranted entries report payload_addr 0.
module first_fit_block_allocator_unit #(
    parameter int POOL_BYTES   = ffba_pkg::POOL_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
    parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire ffba_pkg::ffba_req_t request,
    output logic                     done,
    output ffba_pkg::ffba_rsp_t      result
);

    import ffba_pkg::*;

    localparam int ADDR_W = $clog2(POOL_BYTES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HIT   = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_MERGE = 3'd4;

    logic [2:0]        state_reg, state_next;
    ffba_req_t         req_reg, req_next;
    logic              done_reg, done_next;
    ffba_rsp_t         rsp_reg, rsp_next;

    ffba_ctrl_t        ctrl;
    ffba_stat_t        stat_arr      [MAX_BLOCKS];
    logic [ADDR_W-1:0] start_arr     [MAX_BLOCKS];
    logic [ADDR_W-1:0] bytes_arr     [MAX_BLOCKS];
    logic [ADDR_W-1:0] rem_start_arr [MAX_BLOCKS];
    logic [ADDR_W-1:0] rem_bytes_arr [MAX_BLOCKS];
    logic [PADDR_W-1:0] paddr_arr    [MAX_BLOCKS];

    logic [MAX_BLOCKS-1:0] flag_vec;
    logic [MAX_BLOCKS-1:0] first_vec;
    logic [MAX_BLOCKS-1:0] split_vec;
    logic [MAX_BLOCKS-1:0] valid_vec;
    logic [MAX_BLOCKS-1:0] pre_vec;
    logic                  any_flag;
    logic                  table_full;
    logic [PADDR_W-1:0]    grant_addr;
    logic                  accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start & ~busy;
    assign done   = done_reg;
    assign result = rsp_reg;

    // Row of table cells, each wired to its two neighbors.
    for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
        ffba_stat_t        left_stat;
        logic [ADDR_W-1:0] left_start;
        logic [ADDR_W-1:0] left_bytes;
        logic [ADDR_W-1:0] left_rem_start;
        logic [ADDR_W-1:0] left_rem_bytes;
        ffba_stat_t        right_stat;
        logic [ADDR_W-1:0] right_start;
        logic [ADDR_W-1:0] right_bytes;

        if (k == 0) begin : g_left_edge
            assign left_stat      = '0;
            assign left_start     = '0;
            assign left_bytes     = '0;
            assign left_rem_start = '0;
            assign left_rem_bytes = '0;
        end
        else begin : g_left
            assign left_stat      = stat_arr[k-1];
            assign left_start     = start_arr[k-1];
            assign left_bytes     = bytes_arr[k-1];
            assign left_rem_start = rem_start_arr[k-1];
            assign left_rem_bytes = rem_bytes_arr[k-1];
        end

        if (k == MAX_BLOCKS - 1) begin : g_right_edge
            assign right_stat  = '0;
            assign right_start = '0;
            assign right_bytes = '0;
        end
        else begin : g_right
            assign right_stat  = stat_arr[k+1];
            assign right_start = start_arr[k+1];
            assign right_bytes = bytes_arr[k+1];
        end

        ffba_cell #(
            .POOL_BYTES   (POOL_BYTES),
            .HEADER_BYTES (HEADER_BYTES),
            .IS_HEAD      (k == 0)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .pre            (pre_vec[k]),
            .left_stat      (left_stat),
            .left_start     (left_start),
            .left_bytes     (left_bytes),
            .left_rem_start (left_rem_start),
            .left_rem_bytes (left_rem_bytes),
            .right_stat     (right_stat),
            .right_bytes    (right_bytes),
            .right_start    (right_start),
            .stat           (stat_arr[k]),
            .start          (start_arr[k]),
            .bytes          (bytes_arr[k]),
            .rem_start      (rem_start_arr[k]),
            .rem_bytes      (rem_bytes_arr[k]),
            .paddr          (paddr_arr[k])
        );

        assign flag_vec[k]  = stat_arr[k].flag;
        assign first_vec[k] = stat_arr[k].first;
        assign split_vec[k] = stat_arr[k].first & stat_arr[k].split_ok;
        assign valid_vec[k] = stat_arr[k].valid;
    end

    // Finds the first flagged cell for every cell at once.
    ffba_prefix #(
        .N (MAX_BLOCKS)
    ) u_prefix (
        .flags (flag_vec),
        .pre   (pre_vec),
        .any   (any_flag)
    );

    // The table is full when the last cell holds a block.
    assign table_full = valid_vec[MAX_BLOCKS-1];

    // Payload offset of the granted block; only the first cell drives it.
    always_comb
    begin
        grant_addr = '0;
        for (int k = 0; k < MAX_BLOCKS; k++)
        begin
            grant_addr = grant_addr | paddr_arr[k];
        end
    end

    // Command to the cell row.
    always_comb
    begin
        ctrl.req_size  = req_reg.req_size;
        ctrl.free_addr = req_reg.free_addr;
        ctrl.do_split  = (|split_vec) & ~table_full;
        case (state_reg)
            S_HIT:   ctrl.mode = (req_reg.op == OP_ALLOC) ? MODE_HIT_ALLOC : MODE_HIT_FREE;
            S_ALLOC: ctrl.mode = MODE_ALLOC;
            S_MARK:  ctrl.mode = MODE_MARK;
            S_MERGE: ctrl.mode = MODE_MERGE;
            default: ctrl.mode = MODE_IDLE;
        endcase
    end

    // Request sequencer.
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = request;
                    state_next = S_HIT;
                end
            end
            S_HIT:
            begin
                if (req_reg.op == OP_ALLOC)
                begin
                    state_next = S_ALLOC;
                end
                else if (req_reg.null_pointer)
                begin
                    done_next           = 1'b1;
                    rsp_next.status       = ST_NULL;
                    rsp_next.payload_addr = '0;
                    state_next          = S_IDLE;
                end
                else
                begin
                    state_next = S_MARK;
                end
            end
            S_ALLOC:
            begin
                done_next             = 1'b1;
                rsp_next.status       = any_flag ? ST_DONE : ST_NOFIT;
                rsp_next.payload_addr = grant_addr;
                state_next            = S_IDLE;
            end
            S_MARK:
            begin
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (!any_flag)
                begin
                    done_next             = 1'b1;
                    rsp_next.status       = ST_DONE;
                    rsp_next.payload_addr = '0;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state is reset; the request and result payload are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // Occupied cells always form one run that starts at the head cell.
    logic [MAX_BLOCKS:0] valid_inc;
    assign valid_inc = {1'b0, valid_vec} + (MAX_BLOCKS + 1)'(1);

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_vec[0])
        else $error("head table cell lost its block");

    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(valid_inc))
        else $error("occupied table cells are not contiguous");

    a_one_grant: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(first_vec))
        else $error("more than one cell selected");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat shown while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat held for more than one cycle");

endmodule

`default_nettype wire

// ===== src/ffba_prefix.sv =====
`default_nettype none

// Exclusive prefix OR over the cell flags, built as a log-depth network.
module ffba_prefix #(
    parameter int N = 128
) (
    input  wire logic [N-1:0] flags,
    output logic      [N-1:0] pre,
    output logic              any
);

    localparam int LVL = (N > 1) ? $clog2(N) : 1;

    logic [N-1:0] lvl [LVL+1];

    assign lvl[0] = flags;

    // Each level folds in the flags a power of two further to the left.
    for (genvar s = 0; s < LVL; s++) begin : g_lvl
        for (genvar i = 0; i < N; i++) begin : g_bit
            if (i >= (1 << s)) begin : g_or
                assign lvl[s+1][i] = lvl[s][i] | lvl[s][i-(1<<s)];
            end
            else begin : g_pass
                assign lvl[s+1][i] = lvl[s][i];
            end
        end
    end

    // Shift the inclusive prefix by one place to make it exclusive.
    assign pre = {lvl[LVL][N-2:0], 1'b0};
    assign any = lvl[LVL][N-1];

endmodule

`default_nettype wire

// ===== src/ffba_cell.sv =====
`default_nettype none

// One entry of the block table. It holds one block and trades entries with
// its neighbors when the table is split or merged.
module ffba_cell #(
    parameter int POOL_BYTES   = 2048,
    parameter int HEADER_BYTES = 24,
    parameter bit IS_HEAD      = 1'b0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ffba_pkg::ffba_ctrl_t       ctrl,
    input  wire logic                       pre,
    input  wire ffba_pkg::ffba_stat_t       left_stat,
    input  wire logic [$clog2(POOL_BYTES)-1:0] left_start,
    input  wire logic [$clog2(POOL_BYTES)-1:0] left_bytes,
    input  wire logic [$clog2(POOL_BYTES)-1:0] left_rem_start,
    input  wire logic [$clog2(POOL_BYTES)-1:0] left_rem_bytes,
    input  wire ffba_pkg::ffba_stat_t       right_stat,
    input  wire logic [$clog2(POOL_BYTES)-1:0] right_bytes,
    input  wire logic [$clog2(POOL_BYTES)-1:0] right_start,
    output ffba_pkg::ffba_stat_t            stat,
    output logic [$clog2(POOL_BYTES)-1:0]   start,
    output logic [$clog2(POOL_BYTES)-1:0]   bytes,
    output logic [$clog2(POOL_BYTES)-1:0]   rem_start,
    output logic [$clog2(POOL_BYTES)-1:0]   rem_bytes,
    output logic [ffba_pkg::PADDR_W-1:0]    paddr
);

    import ffba_pkg::*;

    localparam int ADDR_W = $clog2(POOL_BYTES);
    localparam int CMP_W  = ((ADDR_W > REQ_W) ? ADDR_W : REQ_W) + 2;

    logic              valid_reg, valid_next;
    logic              free_reg, free_next;
    logic [ADDR_W-1:0] start_reg, start_next;
    logic [ADDR_W-1:0] bytes_reg, bytes_next;
    logic              hit_reg, hit_next;
    logic              split_ok_reg, split_ok_next;

    logic [CMP_W-1:0]  start_c;
    logic [CMP_W-1:0]  bytes_c;
    logic [CMP_W-1:0]  req_c;
    logic [CMP_W-1:0]  hdr_c;
    logic [CMP_W-1:0]  payload_c;
    logic [CMP_W-1:0]  merged_c;
    logic              pair;
    logic              flag;
    logic              first;

    // Operands widened so that no sum or compare can overflow.
    assign start_c   = CMP_W'(start_reg);
    assign bytes_c   = CMP_W'(bytes_reg);
    assign req_c     = CMP_W'(ctrl.req_size);
    assign hdr_c     = CMP_W'(HEADER_BYTES);
    assign payload_c = start_c + hdr_c;
    assign merged_c  = bytes_c + hdr_c + CMP_W'(right_bytes);

    // This block and the next one are both free and can be merged.
    assign pair  = valid_reg & free_reg & right_stat.valid & right_stat.free;
    assign flag  = (ctrl.mode == MODE_MERGE) ? pair : hit_reg;
    assign first = flag & ~pre;

    // Free remainder left over when this block is split.
    assign rem_start = ADDR_W'(payload_c + req_c);
    assign rem_bytes = ADDR_W'(bytes_c - req_c - hdr_c);

    assign start = start_reg;
    assign bytes = bytes_reg;
    assign paddr = first ? payload_c[PADDR_W-1:0] : '0;

    assign stat.valid    = valid_reg;
    assign stat.free     = free_reg;
    assign stat.flag     = flag;
    assign stat.first    = first;
    assign stat.split_ok = split_ok_reg;

    // Next entry, chosen by the command of this cycle.
    always_comb
    begin
        valid_next    = valid_reg;
        free_next     = free_reg;
        start_next    = start_reg;
        bytes_next    = bytes_reg;
        hit_next      = hit_reg;
        split_ok_next = split_ok_reg;
        case (ctrl.mode)
            MODE_HIT_ALLOC:
            begin
                hit_next      = valid_reg & free_reg & (bytes_c >= req_c);
                split_ok_next = bytes_c >= (req_c + hdr_c);
            end
            MODE_HIT_FREE:
            begin
                hit_next      = valid_reg & (payload_c == CMP_W'(ctrl.free_addr));
                split_ok_next = 1'b0;
            end
            MODE_ALLOC:
            begin
                if (first)
                begin
                    free_next = 1'b0;
                    if (ctrl.do_split)
                    begin
                        bytes_next = ADDR_W'(req_c);
                    end
                end
                else if (ctrl.do_split && pre)
                begin
                    // Entries behind the split block move one place up.
                    if (left_stat.first)
                    begin
                        valid_next = 1'b1;
                        free_next  = 1'b1;
                        start_next = left_rem_start;
                        bytes_next = left_rem_bytes;
                    end
                    else
                    begin
                        valid_next = left_stat.valid;
                        free_next  = left_stat.free;
                        start_next = left_start;
                        bytes_next = left_bytes;
                    end
                end
            end
            MODE_MARK:
            begin
                if (first)
                begin
                    free_next = 1'b1;
                end
            end
            MODE_MERGE:
            begin
                if (first)
                begin
                    bytes_next = ADDR_W'(merged_c);
                end
                else if (pre)
                begin
                    // Entries behind the merged pair move one place down.
                    valid_next = right_stat.valid;
                    free_next  = right_stat.free;
                    start_next = right_start;
                    bytes_next = right_bytes;
                end
            end
            default:
            begin
                hit_next = hit_reg;
            end
        endcase
    end

    // The head cell starts out as one free block spanning the pool.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= IS_HEAD;
            free_reg     <= IS_HEAD;
            start_reg    <= '0;
            bytes_reg    <= IS_HEAD ? ADDR_W'(POOL_BYTES - HEADER_BYTES) : '0;
            hit_reg      <= 1'b0;
            split_ok_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            free_reg     <= free_next;
            start_reg    <= start_next;
            bytes_reg    <= bytes_next;
            hit_reg      <= hit_next;
            split_ok_reg <= split_ok_next;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
    import ffba_pkg::*;

    localparam int POOL_BYTES   = POOL_BYTES_DEF;
    localparam int HEADER_BYTES = HEADER_BYTES_DEF;
    localparam int MAX_BLOCKS   = MAX_BLOCKS_DEF;
    localparam int RANDOM_BEATS = 1500;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_GAP      = 12;

    // One row of the directed table; typed rows carry their own expected result.
    typedef struct {
        ffba_req_t req;
        bit        typed;
        ffba_rsp_t rsp;
    } dir_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    ffba_req_t request = '0;
    logic      busy;
    logic      done;
    ffba_rsp_t result;

    // Shadow copy of the block table.
    logic [PADDR_W-1:0] tbl_start [MAX_BLOCKS];
    logic [REQ_W-1:0]   tbl_bytes [MAX_BLOCKS];
    bit                 tbl_free  [MAX_BLOCKS];
    int                 tbl_count;

    ffba_rsp_t          outcome_q [$];
    logic [PADDR_W-1:0] live_addrs [$];
    logic [PADDR_W-1:0] freed_addrs [$];
    dir_row_t           rows [$];
    ffba_rsp_t          head_rsp;
    int                 mismatches = 0;
    int                 stall_cycles = 0;
    bit                 idle_en = 1'b1;

    first_fit_block_allocator_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Free-running clock, period 8.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Merge every run of adjacent free blocks, whatever its length.
    function automatic void merge_free_runs();
        int i;
        int k;
        i = 0;
        while (i + 1 < tbl_count)
        begin
            if (tbl_free[i] && tbl_free[i + 1])
            begin
                tbl_bytes[i] = REQ_W'(int'(tbl_bytes[i]) + HEADER_BYTES
                                      + int'(tbl_bytes[i + 1]));
                for (k = i + 1; k + 1 < tbl_count; k++)
                begin
                    tbl_start[k] = tbl_start[k + 1];
                    tbl_bytes[k] = tbl_bytes[k + 1];
                    tbl_free[k]  = tbl_free[k + 1];
                end
                tbl_count--;
                tbl_start[tbl_count] = '0;
                tbl_bytes[tbl_count] = '0;
                tbl_free[tbl_count]  = 1'b0;
            end
            else
            begin
                i++;
            end
        end
    endfunction

    // Apply one request beat to the shadow table and return its result.
    function automatic ffba_rsp_t pool_update(input ffba_req_t r);
        ffba_rsp_t o;
        int        i;
        int        k;
        int        sz;
        bit        found;
        o.status       = ST_DONE;
        o.payload_addr = '0;
        sz             = int'(r.req_size);
        found          = 1'b0;
        if (r.op == OP_ALLOC)
        begin
            for (i = 0; i < tbl_count && !found; i++)
            begin
                if (tbl_free[i] && int'(tbl_bytes[i]) >= sz)
                begin
                    found = 1'b1;
                    // Split off the remainder when it can hold a header and the table is not full.
                    if (int'(tbl_bytes[i]) >= sz + HEADER_BYTES && tbl_count < MAX_BLOCKS)
                    begin
                        for (k = tbl_count; k > i + 1; k--)
                        begin
                            tbl_start[k] = tbl_start[k - 1];
                            tbl_bytes[k] = tbl_bytes[k - 1];
                            tbl_free[k]  = tbl_free[k - 1];
                        end
                        tbl_start[i + 1] = PADDR_W'(int'(tbl_start[i]) + HEADER_BYTES + sz);
                        tbl_bytes[i + 1] = REQ_W'(int'(tbl_bytes[i]) - sz - HEADER_BYTES);
                        tbl_free[i + 1]  = 1'b1;
                        tbl_bytes[i]     = REQ_W'(sz);
                        tbl_count++;
                    end
                    tbl_free[i]    = 1'b0;
                    o.payload_addr = PADDR_W'(int'(tbl_start[i]) + HEADER_BYTES);
                end
            end
            if (!found)
                o.status = ST_NOFIT;
        end
        else if (r.null_pointer)
        begin
            o.status = ST_NULL;
        end
        else
        begin
            // Only an exact payload offset names a block.
            for (i = 0; i < tbl_count && !found; i++)
            begin
                if (int'(tbl_start[i]) + HEADER_BYTES == int'(r.free_addr))
                begin
                    found       = 1'b1;
                    tbl_free[i] = 1'b1;
                    merge_free_runs();
                end
            end
        end
        return o;
    endfunction

    function automatic dir_row_t mk_row(input logic op, input int sz, input int fa,
                                        input logic np, input bit typed,
                                        input logic [ST_W-1:0] st, input int pa);
        dir_row_t row;
        row.req.op               = op;
        row.req.req_size         = REQ_W'(sz);
        row.req.free_addr        = FADDR_W'(fa);
        row.req.null_pointer     = np;
        row.typed                = typed;
        row.rsp.status           = st;
        row.rsp.payload_addr     = PADDR_W'(pa);
        return row;
    endfunction

    // Offer one request beat, wait for it to be taken, and record the outcome.
    task automatic send_beat(input ffba_req_t r, input bit typed, input ffba_rsp_t typed_rsp);
        ffba_rsp_t p;
        int        gap;
        if (idle_en && $urandom_range(99) < 32)
        begin
            start <= 1'b0;
            gap = $urandom_range(MAX_GAP, 1);
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        p = pool_update(r);
        outcome_q.push_back(typed ? typed_rsp : p);
        if (r.op == OP_ALLOC && p.status == ST_DONE)
            live_addrs.push_back(p.payload_addr);
    endtask

    // Compare each result beat with the oldest outcome awaited.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing awaited: status %0d addr %0d",
                                          result.status, result.payload_addr));
            end
            else
            begin
                head_rsp = outcome_q.pop_front();
                if (result.status !== head_rsp.status)
                    report_mismatch($sformatf("status %0d, awaited %0d",
                                              result.status, head_rsp.status));
                if (result.payload_addr !== head_rsp.payload_addr)
                    report_mismatch($sformatf("payload_addr %0d, awaited %0d",
                                              result.payload_addr, head_rsp.payload_addr));
            end
        end
    end

    // Watchdog on cycles with no beat moving in either direction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        ffba_req_t r;
        ffba_rsp_t none;
        int        n;
        int        choice;
        int        idx;
        none = '0;

        // Shadow table after reset: one free block spanning the pool.
        for (n = 0; n < MAX_BLOCKS; n++)
        begin
            tbl_start[n] = '0;
            tbl_bytes[n] = '0;
            tbl_free[n]  = 1'b0;
        end
        tbl_bytes[0] = REQ_W'(POOL_BYTES - HEADER_BYTES);
        tbl_free[0]  = 1'b1;
        tbl_count    = 1;

        // Directed table.
        rows.push_back(mk_row(OP_ALLOC, 0,    0,    1'b0, 1, ST_DONE,  24));
        rows.push_back(mk_row(OP_ALLOC, 4095, 0,    1'b0, 1, ST_NOFIT, 0));
        rows.push_back(mk_row(OP_FREE,  0,    2047, 1'b1, 1, ST_NULL,  0));
        rows.push_back(mk_row(OP_FREE,  4095, 2047, 1'b0, 1, ST_DONE,  0));
        rows.push_back(mk_row(OP_ALLOC, 100,  2047, 1'b1, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_ALLOC, 10,   0,    1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_ALLOC, 10,   0,    1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_ALLOC, 10,   0,    1'b0, 0, ST_DONE,  0));
        // Free the outer two first, then the middle one to merge a run of three.
        rows.push_back(mk_row(OP_FREE,  0,    48,   1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_FREE,  0,    206,  1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_FREE,  0,    172,  1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_FREE,  0,    48,   1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_FREE,  0,    24,   1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_FREE,  0,    240,  1'b0, 0, ST_DONE,  0));
        // Whole pool free again: the largest payload is granted without a split.
        rows.push_back(mk_row(OP_ALLOC, 2024, 0,    1'b0, 1, ST_DONE,  24));
        rows.push_back(mk_row(OP_ALLOC, 0,    0,    1'b0, 1, ST_NOFIT, 0));
        rows.push_back(mk_row(OP_FREE,  0,    24,   1'b0, 1, ST_DONE,  0));
        rows.push_back(mk_row(OP_ALLOC, 2001, 0,    1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_FREE,  0,    24,   1'b0, 0, ST_DONE,  0));
        // Exact split leaves a zero-byte free block, then a zero-size request takes it.
        rows.push_back(mk_row(OP_ALLOC, 2000, 0,    1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_ALLOC, 0,    0,    1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_FREE,  0,    24,   1'b0, 0, ST_DONE,  0));
        rows.push_back(mk_row(OP_ALLOC, 4095, 2047, 1'b1, 1, ST_NOFIT, 0));
        rows.push_back(mk_row(OP_FREE,  0,    0,    1'b0, 1, ST_DONE,  0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < rows.size(); n++)
            send_beat(rows[n].req, rows[n].typed, rows[n].rsp);
        live_addrs.delete();

        // Random traffic: mostly allocations and releases of live blocks.
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            idle_en            = !(n >= 500 && n < 800);
            choice             = $urandom_range(99);
            r.op               = OP_ALLOC;
            r.req_size         = REQ_W'($urandom_range(4095));
            r.free_addr        = FADDR_W'($urandom_range(2047));
            r.null_pointer     = 1'($urandom_range(1));
            if (choice >= 48 && choice < 88 && live_addrs.size() != 0)
            begin
                idx            = $urandom_range(live_addrs.size() - 1);
                r.op           = OP_FREE;
                r.free_addr    = live_addrs[idx];
                r.null_pointer = 1'b0;
                live_addrs.delete(idx);
                freed_addrs.push_back(r.free_addr);
                if (freed_addrs.size() > 16)
                    void'(freed_addrs.pop_front());
            end
            else if (choice >= 88 && choice < 93)
            begin
                r.op           = OP_FREE;
                r.null_pointer = 1'b0;
            end
            else if (choice >= 93 && choice < 96 && freed_addrs.size() != 0)
            begin
                r.op           = OP_FREE;
                r.free_addr    = freed_addrs[$urandom_range(freed_addrs.size() - 1)];
                r.null_pointer = 1'b0;
            end
            else if (choice >= 96)
            begin
                r.op           = OP_FREE;
                r.null_pointer = 1'b1;
            end
            else
            begin
                // Size mix: mostly small, a few up to and beyond the pool.
                idx = $urandom_range(99);
                if (idx < 70)
                    r.req_size = REQ_W'($urandom_range(64));
                else if (idx < 90)
                    r.req_size = REQ_W'($urandom_range(400, 65));
                else if (idx < 97)
                    r.req_size = REQ_W'($urandom_range(2047, 401));
                else
                    r.req_size = REQ_W'($urandom_range(4095, 2048));
            end
            send_beat(r, 1'b0, none);
        end
        start <= 1'b0;

        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
